FILE: src/crfk_pkg.sv
`timescale 1ns / 1ps
package crfk_pkg;

  localparam int LEN_W   = 24;
  localparam int SQ_W    = 2 * LEN_W;
  localparam int NUM_W   = 52;
  localparam int MAG_W   = NUM_W - 1;
  localparam int SPAN_W  = 15;
  localparam int DROP_W  = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_A_W = 2;
  localparam int C_W     = SPAN_W + 1;
  localparam int DIV_W   = SPAN_W + 4;
  localparam int POS_W   = 24;
  localparam int Q_BITS  = POS_W - 1;
  localparam int CNT_W   = $clog2(Q_BITS);
  localparam int ST_W    = 2;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(7680);

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_SHORT = 2'd1;
  localparam logic [ST_W-1:0] ST_SING  = 2'd2;

  localparam logic [CFG_A_W-1:0] REG_SPAN  = 2'd0;
  localparam logic [CFG_A_W-1:0] REG_OFF_X = 2'd1;
  localparam logic [CFG_A_W-1:0] REG_OFF_Y = 2'd2;
  localparam logic [CFG_A_W-1:0] REG_DROP  = 2'd3;

  typedef struct packed {
    logic signed [NUM_W-1:0] nx;
    logic signed [NUM_W-1:0] ny;
    logic                    short_cable;
  } q_entry_t;

  typedef struct packed {
    logic signed [C_W-1:0] cx;
    logic signed [C_W-1:0] cy;
  } geom_t;

endpackage

FILE: src/crfk_front.sv
`timescale 1ns / 1ps
module crfk_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [4*crfk_pkg::LEN_W-1:0] in_tdata,
  input  logic [crfk_pkg::DROP_W-1:0]  drop,
  input  logic                         q_full,
  output logic                         q_wr,
  output crfk_pkg::q_entry_t           q_wdata
);
  import crfk_pkg::*;

  logic              en;
  logic              s1_v_r, s2_v_r;
  logic [SQ_W-1:0]   sq_r [4];
  logic              sh1_r;
  q_entry_t          ent_r;
  logic [LEN_W-1:0]  len [4];
  logic [3:0]        below;

  assign en        = !s2_v_r || !q_full;
  assign in_tready = en;
  assign q_wr      = s2_v_r && !q_full;
  assign q_wdata   = ent_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      len[i]   = in_tdata[i*LEN_W +: LEN_W];
      below[i] = len[i] < LEN_W'(drop);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_tvalid;
      s2_v_r <= s1_v_r;
    end
  end

  // drop squared cancels in the differences, so only raw squares are needed
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) sq_r[i] <= SQ_W'(len[i]) * SQ_W'(len[i]);
      sh1_r <= |below;
      ent_r.short_cable <= sh1_r;
      ent_r.nx <= ($signed({4'b0, sq_r[0]}) <<< 1) - $signed({4'b0, sq_r[1]})
                - ($signed({4'b0, sq_r[2]}) <<< 1) + $signed({4'b0, sq_r[3]});
      ent_r.ny <= ($signed({4'b0, sq_r[0]}) <<< 1) - $signed({4'b0, sq_r[1]})
                + $signed({4'b0, sq_r[2]}) - ($signed({4'b0, sq_r[3]}) <<< 1);
    end
  end

endmodule

FILE: src/crfk_queue.sv
`timescale 1ns / 1ps
module crfk_queue #(
  parameter int DEPTH = crfk_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr,
  input  crfk_pkg::q_entry_t wdata,
  output logic               full,
  input  logic               rd,
  output logic               not_empty,
  output crfk_pkg::q_entry_t rdata
);
  import crfk_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(DEPTH + 1);

  q_entry_t           mem_r [DEPTH];
  logic [PTR_W-1:0]   wp_r, rp_r;
  logic [CNT_W_Q-1:0] cnt_r;

  assign full      = cnt_r == CNT_W_Q'(DEPTH);
  assign not_empty = cnt_r != '0;
  assign rdata     = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (wr && !rd) cnt_r <= cnt_r + 1'b1;
      else if (rd && !wr) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wdata;
  end

endmodule

FILE: src/crfk_back.sv
`timescale 1ns / 1ps
module crfk_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_not_empty,
  input  crfk_pkg::q_entry_t                   q_rdata,
  output logic                                 q_rd,
  input  crfk_pkg::geom_t                      geom,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [2*crfk_pkg::POS_W+7:0]         out_tdata
);
  import crfk_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_PREP, S_DIV, S_FIN} state_t;

  state_t               st_r;
  logic [MAG_W-1:0]     rem_x_r, rem_y_r, dsh_x_r, dsh_y_r;
  logic [Q_BITS-1:0]    qx_r, qy_r;
  logic                 neg_x_r, neg_y_r, ov_x_r, ov_y_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [ST_W-1:0]      stat_r;
  logic                 out_v_r;
  logic [POS_W-1:0]     x_out_r, y_out_r;
  logic [ST_W-1:0]      st_out_r;

  logic [C_W-2:0]       ax, ay;
  logic [DIV_W-1:0]     dx, dy;
  logic [MAG_W-1:0]     mx, my;
  logic                 take;
  logic                 gx, gy;
  logic [POS_W-1:0]     rx, ry;

  assign ax = geom.cx[C_W-1] ? (C_W-1)'(-geom.cx) : geom.cx[C_W-2:0];
  assign ay = geom.cy[C_W-1] ? (C_W-1)'(-geom.cy) : geom.cy[C_W-2:0];
  assign dx = (DIV_W'(ax) << 3) + (DIV_W'(ax) << 2);
  assign dy = (DIV_W'(ay) << 3) + (DIV_W'(ay) << 2);
  assign mx = q_rdata.nx[NUM_W-1] ? MAG_W'(-q_rdata.nx) : q_rdata.nx[MAG_W-1:0];
  assign my = q_rdata.ny[NUM_W-1] ? MAG_W'(-q_rdata.ny) : q_rdata.ny[MAG_W-1:0];

  assign q_rd = (st_r == S_IDLE) && q_not_empty;
  assign take = !out_v_r || out_tready;
  assign gx   = rem_x_r >= dsh_x_r;
  assign gy   = rem_y_r >= dsh_y_r;

  always_comb begin
    if (ov_x_r) rx = neg_x_r ? {1'b1, {Q_BITS{1'b0}}} : {1'b0, {Q_BITS{1'b1}}};
    else        rx = neg_x_r ? POS_W'(-{1'b0, qx_r}) : {1'b0, qx_r};
    if (ov_y_r) ry = neg_y_r ? {1'b1, {Q_BITS{1'b0}}} : {1'b0, {Q_BITS{1'b1}}};
    else        ry = neg_y_r ? POS_W'(-{1'b0, qy_r}) : {1'b0, qy_r};
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {6'b0, st_out_r, y_out_r, x_out_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      out_v_r <= 1'b0;
    end else begin
      // in S_FIN the output register is reloaded below
      if (out_v_r && out_tready && st_r != S_FIN) out_v_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (q_not_empty) begin
            rem_x_r <= mx;
            rem_y_r <= my;
            neg_x_r <= q_rdata.nx[NUM_W-1] ^ geom.cx[C_W-1];
            neg_y_r <= q_rdata.ny[NUM_W-1] ^ geom.cy[C_W-1];
            qx_r    <= '0;
            qy_r    <= '0;
            ov_x_r  <= 1'b0;
            ov_y_r  <= 1'b0;
            if (q_rdata.short_cable) begin
              stat_r <= ST_SHORT;
              st_r   <= S_FIN;
            end else if (ax == '0 || ay == '0) begin
              stat_r <= ST_SING;
              st_r   <= S_FIN;
            end else begin
              stat_r <= ST_OK;
              st_r   <= S_PREP;
            end
          end
        end
        S_PREP: begin
          // quotient of 2^23 or more saturates, so only 23 bits are divided out
          ov_x_r  <= rem_x_r >= (MAG_W'(dx) << Q_BITS);
          ov_y_r  <= rem_y_r >= (MAG_W'(dy) << Q_BITS);
          dsh_x_r <= MAG_W'(dx) << (Q_BITS - 1);
          dsh_y_r <= MAG_W'(dy) << (Q_BITS - 1);
          cnt_r   <= CNT_W'(Q_BITS - 1);
          st_r    <= S_DIV;
        end
        S_DIV: begin
          if (gx) rem_x_r <= rem_x_r - dsh_x_r;
          if (gy) rem_y_r <= rem_y_r - dsh_y_r;
          qx_r    <= {qx_r[Q_BITS-2:0], gx};
          qy_r    <= {qy_r[Q_BITS-2:0], gy};
          dsh_x_r <= dsh_x_r >> 1;
          dsh_y_r <= dsh_y_r >> 1;
          cnt_r   <= cnt_r - 1'b1;
          if (cnt_r == '0) st_r <= S_FIN;
        end
        S_FIN: begin
          if (take) begin
            out_v_r  <= 1'b1;
            st_out_r <= stat_r;
            x_out_r  <= (stat_r == ST_OK) ? rx : '0;
            y_out_r  <= (stat_r == ST_OK) ? ry : '0;
            st_r     <= S_IDLE;
          end else begin
            out_v_r  <= 1'b1;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/cable_robot_forward_kinematics.sv
`timescale 1ns / 1ps
// Path to out_tvalid: the front's square and numerator registers, the queue, then
// the back's idle, prep, divide and finish states; a short cable or singular
// geometry goes from idle straight to finish. The back takes one word at a time
// into the shared 23-step restoring divider pair. The front accepts words back to
// back until the queue (2 entries by default) fills. Reset (rst_n, synchronous,
// active low) empties pipeline and queue and loads span 30.0, zero offsets and zero drop.
module cable_robot_forward_kinematics #(
  parameter int QUEUE_DEPTH = crfk_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // length_1, length_2, length_3, length_4
  input  logic [4*crfk_pkg::LEN_W-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // x_pos, y_pos, status, zero pad
  output logic [2*crfk_pkg::POS_W+7:0]  out_tdata,
  input  logic                          cfg_wr_en,
  input  logic [crfk_pkg::CFG_A_W-1:0]  cfg_addr,
  input  logic [crfk_pkg::CFG_W-1:0]    cfg_wdata
);
  import crfk_pkg::*;

  logic [SPAN_W-1:0] span_r, offx_r, offy_r;
  logic [DROP_W-1:0] drop_r;
  geom_t             geom;
  q_entry_t          q_wdata, q_rdata;
  logic              q_wr, q_rd, q_full, q_ne;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      span_r <= SPAN_RESET;
      offx_r <= '0;
      offy_r <= '0;
      drop_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_SPAN:  span_r <= cfg_wdata[SPAN_W-1:0];
        REG_OFF_X: offx_r <= cfg_wdata[SPAN_W-1:0];
        REG_OFF_Y: offy_r <= cfg_wdata[SPAN_W-1:0];
        REG_DROP:  drop_r <= cfg_wdata[DROP_W-1:0];
        default: ;
      endcase
    end
  end

  assign geom.cx = $signed({1'b0, span_r}) - $signed({1'b0, offx_r});
  assign geom.cy = $signed({1'b0, span_r}) - $signed({1'b0, offy_r});

  crfk_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .drop(drop_r), .q_full(q_full), .q_wr(q_wr), .q_wdata(q_wdata)
  );

  crfk_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr(q_wr), .wdata(q_wdata), .full(q_full),
    .rd(q_rd), .not_empty(q_ne), .rdata(q_rdata)
  );

  crfk_back u_back (
    .clk(clk), .rst_n(rst_n),
    .q_not_empty(q_ne), .q_rdata(q_rdata), .q_rd(q_rd), .geom(geom),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

endmodule
